// File: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned DATA_W    = 32;

	typedef enum logic [2:0] {
		KIND_APPEND     = 3'd0,
		KIND_INSERT     = 3'd1,
		KIND_POP        = 3'd2,
		KIND_REMOVE_AT  = 3'd3,
		KIND_REMOVE_VAL = 3'd4,
		KIND_READ       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         position;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [5:0]         count_after;
		logic [1:0]         status;
		logic [5:0]         removed_count;
	} rsp_t;

endpackage

// File: hw/rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit words in one RAM: append, insert, pop,
// remove at index, remove by value, read.
// ----------------------------------------------------------------------------
//
//  channel   ports                 handshake
//  -------   -------------------   ---------------------------------------
//  request   start, busy, req      taken on an edge with start=1, busy=0
//  result    done, rsp             done high one cycle, word taken then
//
//  Append, the unused kinds, remove by value on an empty list and every
//  flagged request finish in the accept cycle; the result word shows in
//  the next cycle and busy stays low, so one per cycle.
//  Pop, read, insert, remove at index and remove by value walk the RAM
//  one entry per cycle through its one read port, with busy high until
//  the result word is set. Insert at the end reads none. Remove by value
//  reads the whole list.
//  Reset clears the count and control only; RAM contents stay undefined.
//  The receiver cannot stall; done is a pure strobe.
//
module indexed_list_store
	import ils_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > 6) ? CW : 6;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [AW-1:0]      pos_q;
	logic [DATA_W-1:0]  val_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      rd_addr_q;
	logic [AW-1:0]      rd_end_q;
	logic               rd_on_q;
	logic               v_s1;
	logic [AW-1:0]      addr_s1;
	logic [CW-1:0]      kept_q;
	logic [CW-1:0]      removed_q;
	logic [DATA_W-1:0]  res_q;
	logic               done_q;
	rsp_t               rsp_q;

	// RAM port signals
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [DATA_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [DATA_W-1:0]  mem_rdata;

	// accept decode
	logic               accept;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      n_x;
	logic               full;
	logic               empty;
	logic               go_scan;
	logic               acc_rd_on;
	logic [AW-1:0]      acc_start;
	logic [AW-1:0]      acc_end;
	logic [AW-1:0]      acc_pos;
	logic [1:0]         acc_status;
	logic [CW-1:0]      acc_count;
	logic               acc_write;
	logic [AW-1:0]      last_idx;

	// scan datapath
	logic               finish;
	logic               hit;
	logic [CW-1:0]      fin_count;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign pos_x    = XW'(req.position);
	assign n_x      = XW'(count_q);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign last_idx = AW'(count_q - CW'(1));

	always_comb begin
		go_scan    = 1'b0;
		acc_rd_on  = 1'b1;
		acc_start  = '0;
		acc_end    = last_idx;
		acc_pos    = AW'(req.position);
		acc_status = STAT_OK;
		acc_count  = count_q;
		acc_write  = 1'b0;
		case (req.kind)
			KIND_APPEND: begin
				if (full) begin
					acc_status = STAT_FULL;
				end else begin
					acc_write = 1'b1;
					acc_count = count_q + CW'(1);
				end
			end
			KIND_INSERT: begin
				if (pos_x > n_x) begin
					acc_status = STAT_BAD_INDEX;
				end else if (full) begin
					acc_status = STAT_FULL;
				end else begin
					// shift down from the tail; nothing to move at the end
					go_scan   = 1'b1;
					acc_rd_on = (pos_x < n_x);
					acc_start = last_idx;
					acc_end   = AW'(req.position);
				end
			end
			KIND_POP: begin
				if (empty) begin
					acc_status = STAT_EMPTY;
				end else begin
					go_scan   = 1'b1;
					acc_start = last_idx;
					acc_pos   = last_idx;
				end
			end
			KIND_REMOVE_AT: begin
				if (empty) begin
					acc_status = STAT_EMPTY;
				end else if (pos_x >= n_x) begin
					acc_status = STAT_BAD_INDEX;
				end else begin
					go_scan   = 1'b1;
					acc_start = AW'(req.position);
				end
			end
			KIND_REMOVE_VAL: begin
				// empty list: no match, plain ok
				go_scan = !empty;
			end
			KIND_READ: begin
				if (empty) begin
					acc_status = STAT_EMPTY;
				end else if (pos_x >= n_x) begin
					acc_status = STAT_BAD_INDEX;
				end else begin
					go_scan   = 1'b1;
					acc_start = AW'(req.position);
					acc_end   = AW'(req.position);
				end
			end
			default: begin
				// unused codes answer ok with no change
			end
		endcase
	end

	// scan done once no read is outstanding
	assign finish = (state_q == ST_SCAN) && !rd_on_q && !v_s1;
	assign hit    = (mem_rdata == val_q);

	always_comb begin
		case (kind_q)
			KIND_INSERT:     fin_count = count_q + CW'(1);
			KIND_POP:        fin_count = count_q - CW'(1);
			KIND_REMOVE_AT:  fin_count = count_q - CW'(1);
			KIND_REMOVE_VAL: fin_count = kept_q;
			default:         fin_count = count_q;
		endcase
	end

	// single write port: accept, scan and finish writes never share a cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		if (accept && acc_write) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(count_q);
			mem_wdata = DATA_W'(req.item_value);
		end else if (v_s1) begin
			case (kind_q)
				KIND_INSERT: begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 + AW'(1);
				end
				KIND_REMOVE_AT: begin
					mem_we    = (addr_s1 != pos_q);
					mem_waddr = addr_s1 - AW'(1);
				end
				KIND_REMOVE_VAL: begin
					mem_we    = !hit;
					mem_waddr = AW'(kept_q);
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end else if (finish && (kind_q == KIND_INSERT)) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q;
			mem_wdata = val_q;
		end
	end

	assign mem_re = (state_q == ST_SCAN) && rd_on_q;

	ils_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_on_q <= 1'b0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (go_scan) begin
							state_q <= ST_SCAN;
							rd_on_q <= acc_rd_on;
						end else begin
							count_q <= acc_count;
							done_q  <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					v_s1 <= rd_on_q;
					if (rd_on_q && (rd_addr_q == rd_end_q)) begin
						rd_on_q <= 1'b0;
					end
					if (finish) begin
						count_q <= fin_count;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind_t'(req.kind);
			pos_q     <= acc_pos;
			val_q     <= DATA_W'(req.item_value);
			rd_addr_q <= acc_start;
			rd_end_q  <= acc_end;
			kept_q    <= '0;
			removed_q <= '0;
			res_q     <= '0;
			if (!go_scan) begin
				rsp_q.result_value  <= '0;
				rsp_q.count_after   <= 6'(acc_count);
				rsp_q.status        <= acc_status;
				rsp_q.removed_count <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			if (rd_on_q) begin
				// insert walks down from the tail, the rest walk up
				if (kind_q == KIND_INSERT) begin
					rd_addr_q <= rd_addr_q - AW'(1);
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
			end
			addr_s1 <= rd_addr_q;
			if (v_s1) begin
				case (kind_q)
					KIND_POP, KIND_READ, KIND_REMOVE_AT: begin
						if (addr_s1 == pos_q) begin
							res_q <= mem_rdata;
						end
					end
					KIND_REMOVE_VAL: begin
						if (hit) begin
							removed_q <= removed_q + CW'(1);
						end else begin
							kept_q <= kept_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (finish) begin
				rsp_q.result_value  <= res_q;
				rsp_q.count_after   <= 6'(fin_count);
				rsp_q.status        <= STAT_OK;
				rsp_q.removed_count <= 6'(removed_q);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: verif/indexed_list_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. A short table of directed
// words covers the empty, bad index and extreme value cases and the spare
// kinds. Random words follow, in fill, drain and mixed phases, so the list
// runs full and empty over and over. Every accepted word is run through a
// shadow list in the bench, and each result word is checked against it in
// order.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
	import ils_pkg::*;

	// kinds the block must ignore
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	localparam int unsigned RANDOM_WORDS = 1300;
	localparam int unsigned PHASE_LEN    = 50;
	// random words in this window go in back to back, with no idle cycles
	localparam int unsigned BURST_FIRST  = 500;
	localparam int unsigned BURST_LAST   = 699;
	localparam int unsigned IDLE_PCT     = 22;
	// longest walk: remove by value over a full list, plus margin
	localparam int unsigned DRAIN_CYCLES = 2 * DEPTH_DEF + 16;
	localparam int unsigned SHOW_MAX     = 10;

	typedef enum int unsigned {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	typedef struct {
		req_t w;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// shadow copy of the list, updated at accept time
	logic signed [31:0] shadow_list [DEPTH_DEF];
	int unsigned        shadow_len;

	rsp_t        pending_rsp [$];
	int unsigned fail_count;
	dir_row_t    dir_rows [$];

	// typed-in expectation for the word now on the request port
	bit   pin_typed;
	rsp_t pin_want;

	indexed_list_store u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop, far above the slowest legal run
	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow list: applies one word and returns the result word it owes.
	// Flagged words leave the list alone; result_value and removed_count
	// stay zero unless the operation produces them.
	// ------------------------------------------------------------------
	function automatic rsp_t list_apply(input req_t w);
		rsp_t        o;
		int unsigned n;
		int unsigned kept;
		int unsigned i;
		o = '0;
		o.status = STAT_OK;
		n = shadow_len;
		case (w.kind)
			KIND_APPEND: begin
				if (n >= DEPTH_DEF) begin
					o.status = STAT_FULL;
				end else begin
					shadow_list[n] = w.item_value;
					n++;
				end
			end
			KIND_INSERT: begin
				// index check wins over the full check
				if (w.position > n) begin
					o.status = STAT_BAD_INDEX;
				end else if (n >= DEPTH_DEF) begin
					o.status = STAT_FULL;
				end else begin
					for (i = n; i > w.position; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[w.position] = w.item_value;
					n++;
				end
			end
			KIND_POP: begin
				if (n == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					n--;
					o.result_value = shadow_list[n];
				end
			end
			KIND_REMOVE_AT: begin
				if (n == 0) begin
					o.status = STAT_EMPTY;
				end else if (w.position >= n) begin
					o.status = STAT_BAD_INDEX;
				end else begin
					o.result_value = shadow_list[w.position];
					for (i = w.position; i + 1 < n; i++)
						shadow_list[i] = shadow_list[i + 1];
					n--;
				end
			end
			KIND_REMOVE_VAL: begin
				// every match goes, adjacent duplicates too; order is kept
				kept = 0;
				for (i = 0; i < n; i++) begin
					if (shadow_list[i] == w.item_value) begin
						o.removed_count = o.removed_count + 6'd1;
					end else begin
						shadow_list[kept] = shadow_list[i];
						kept++;
					end
				end
				n = kept;
			end
			KIND_READ: begin
				if (n == 0)
					o.status = STAT_EMPTY;
				else if (w.position >= n)
					o.status = STAT_BAD_INDEX;
				else
					o.result_value = shadow_list[w.position];
			end
			default: begin
				// spare kinds: no change, plain ok
			end
		endcase
		shadow_len = n;
		o.count_after = n[5:0];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Random word for one phase. Kind comes from cumulative weights;
	// positions are mostly legal for the current length, the rest span
	// the whole 6-bit field. Values lean on a small pool so duplicates
	// pile up for remove by value.
	// ------------------------------------------------------------------
	function automatic req_t pick_word(input phase_t ph);
		req_t        w;
		int unsigned bounds [6];
		int unsigned d;
		int unsigned k;
		bit          legal;
		case (ph)
			PH_FILL:  bounds = '{40, 65, 70, 74, 80, 96};
			PH_DRAIN: bounds = '{8, 16, 40, 64, 78, 96};
			default:  bounds = '{20, 38, 52, 66, 78, 96};
		endcase
		d = $urandom_range(0, 99);
		k = 6;
		for (int unsigned j = 0; j < 6; j++) begin
			if (k == 6 && d < bounds[j])
				k = j;
		end
		if (k == 6)
			w.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
		else
			w.kind = k[2:0];

		legal = ($urandom_range(0, 99) < 85);
		w.position = $urandom_range(0, 63);
		if (legal) begin
			if (w.kind == KIND_INSERT)
				w.position = $urandom_range(0, shadow_len);
			else if ((w.kind == KIND_REMOVE_AT || w.kind == KIND_READ) && shadow_len > 0)
				w.position = $urandom_range(0, shadow_len - 1);
		end

		if (w.kind == KIND_REMOVE_VAL && shadow_len > 0 && $urandom_range(0, 99) < 70)
			w.item_value = shadow_list[$urandom_range(0, shadow_len - 1)];
		else if ($urandom_range(0, 99) < 40)
			w.item_value = $signed($urandom_range(0, 3)) - 2;
		else
			w.item_value = $urandom;
		return w;
	endfunction

	// table rows: one checked against the shadow list, one with a typed-in answer
	task automatic row_pred(input logic [2:0] k, input logic [5:0] pos,
		input logic signed [31:0] val);
		dir_row_t r;
		r.w = '{kind: k, position: pos, item_value: val};
		r.typed = 1'b0;
		r.want = '0;
		dir_rows.push_back(r);
	endtask

	task automatic row_typed(input logic [2:0] k, input logic [5:0] pos,
		input logic signed [31:0] val, input logic signed [31:0] res,
		input logic [5:0] cnt, input status_t st);
		dir_row_t r;
		r.w = '{kind: k, position: pos, item_value: val};
		r.typed = 1'b1;
		r.want = '{result_value: res, count_after: cnt, status: st, removed_count: 6'd0};
		dir_rows.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Send one word. Called right after a falling edge; may idle first,
	// then holds start until the block takes the word.
	// ------------------------------------------------------------------
	task automatic send_word(input req_t w, input bit typed, input rsp_t want,
		input bit may_idle);
		while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			@(negedge clk);
		end
		pin_typed = typed;
		pin_want = want;
		start <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	// ------------------------------------------------------------------
	// Scoreboard. Checks a result word against the oldest expectation
	// first, then records the word accepted on this edge, so a result can
	// never be matched against the word taken in the same cycle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_MAX)
						$display("%0t: result word with none expected: res=%0d cnt=%0d st=%0d rm=%0d",
							$realtime, rsp.result_value, rsp.count_after, rsp.status,
							rsp.removed_count);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.result_value !== want.result_value
						|| rsp.count_after !== want.count_after
						|| rsp.status !== want.status
						|| rsp.removed_count !== want.removed_count) begin
						fail_count++;
						if (fail_count <= SHOW_MAX)
							$display("%0t: mismatch exp res=%0d cnt=%0d st=%0d rm=%0d, got res=%0d cnt=%0d st=%0d rm=%0d",
								$realtime, want.result_value, want.count_after, want.status,
								want.removed_count, rsp.result_value, rsp.count_after,
								rsp.status, rsp.removed_count);
					end
				end
			end
			if (start && !busy) begin
				// shadow list always moves; a typed-in answer overrides its result
				want = list_apply(req);
				if (pin_typed)
					want = pin_want;
				pending_rsp.push_back(want);
			end
		end
	end

	initial begin : stimulus
		req_t   w;
		phase_t ph;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		pin_typed = 1'b0;
		pin_want = '0;
		shadow_len = 0;
		fail_count = 0;
		for (int i = 0; i < DEPTH_DEF; i++)
			shadow_list[i] = '0;

		// empty list after reset
		row_typed(KIND_POP,        6'd0,  32'sd0, 32'sd0, 6'd0, STAT_EMPTY);
		row_typed(KIND_READ,       6'd0,  32'sd0, 32'sd0, 6'd0, STAT_EMPTY);
		row_typed(KIND_REMOVE_AT,  6'd0,  32'sd0, 32'sd0, 6'd0, STAT_EMPTY);
		row_typed(KIND_INSERT,     6'd1,  32'sd9, 32'sd0, 6'd0, STAT_BAD_INDEX);
		row_typed(KIND_INSERT,     6'd63, 32'sd9, 32'sd0, 6'd0, STAT_BAD_INDEX);
		row_typed(KIND_REMOVE_VAL, 6'd0,  32'sd0, 32'sd0, 6'd0, STAT_OK);
		row_typed(KIND_SPARE_B,    6'd0,  32'sd0, 32'sd0, 6'd0, STAT_OK);
		// value extremes, prepend, insert at the end
		row_typed(KIND_APPEND, 6'd0, 32'sh8000_0000, 32'sd0, 6'd1, STAT_OK);
		row_typed(KIND_APPEND, 6'd0, 32'sh7FFF_FFFF, 32'sd0, 6'd2, STAT_OK);
		row_typed(KIND_INSERT, 6'd0, -32'sd1,        32'sd0, 6'd3, STAT_OK);
		row_typed(KIND_INSERT, 6'd3, 32'sd0,         32'sd0, 6'd4, STAT_OK);
		row_pred(KIND_INSERT, 6'd2, 32'sd5);
		row_pred(KIND_READ,   6'd0, 32'sd0);
		row_pred(KIND_READ,   6'd1, 32'sd0);
		// index at and past the count, spare kind with every position and value bit set
		row_typed(KIND_READ,      6'd5,  32'sd0,  32'sd0, 6'd5, STAT_BAD_INDEX);
		row_typed(KIND_READ,      6'd63, 32'sd0,  32'sd0, 6'd5, STAT_BAD_INDEX);
		row_typed(KIND_REMOVE_AT, 6'd5,  32'sd0,  32'sd0, 6'd5, STAT_BAD_INDEX);
		row_typed(KIND_SPARE_A,   6'd63, -32'sd1, 32'sd0, 6'd5, STAT_OK);
		// duplicates, one of them adjacent, then remove by value
		row_pred(KIND_APPEND,     6'd0, 32'sd5);
		row_pred(KIND_APPEND,     6'd0, 32'sd5);
		row_pred(KIND_REMOVE_VAL, 6'd0, 32'sd5);
		row_pred(KIND_REMOVE_AT,  6'd0, 32'sd0);
		row_pred(KIND_REMOVE_VAL, 6'd0, 32'sd12345);
		row_pred(KIND_POP,        6'd0, 32'sd0);
		row_typed(KIND_READ, 6'd31, 32'sd0, 32'sd0, 6'd2, STAT_BAD_INDEX);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			@(negedge clk);
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want, 1'b1);
		end

		// fill, drain, mixed, over and over: full and empty both get hit often
		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			@(negedge clk);
			ph = phase_t'((i / PHASE_LEN) % 3);
			w = pick_word(ph);
			send_word(w, 1'b0, '0, !(i >= BURST_FIRST && i <= BURST_LAST));
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
